@@ design/metf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package metf_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int POS_W  = 32;
  localparam int LEN_W  = 31;
  localparam int CIRC_W = 48;
  localparam int ROOT_W = 33;
  localparam int DIFF_W = 33;
  localparam int PROD_W = 66;
  localparam int NUM_W  = 32;
  localparam int CNT_W  = 6;

  localparam logic [2:0] CFG_SIGMA   = 3'd0;
  localparam logic [2:0] CFG_BOX_X   = 3'd1;
  localparam logic [2:0] CFG_BOX_Y   = 3'd2;
  localparam logic [2:0] CFG_BOX_Z   = 3'd3;
  localparam logic [2:0] CFG_VIR_EN  = 3'd4;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_a_x;
    logic signed [POS_W-1:0] pos_a_y;
    logic signed [POS_W-1:0] pos_a_z;
    logic signed [POS_W-1:0] pos_b_x;
    logic signed [POS_W-1:0] pos_b_y;
    logic signed [POS_W-1:0] pos_b_z;
    logic                    is_boundary;
    logic                    first_bond;
  } metf_in_t;

  typedef struct packed {
    logic                    end_select;
    logic signed [POS_W-1:0] force_x;
    logic signed [POS_W-1:0] force_y;
    logic signed [POS_W-1:0] force_z;
    logic [LEN_W-1:0]        end_energy;
    logic signed [POS_W-1:0] virial_xx;
    logic signed [POS_W-1:0] virial_xy;
    logic signed [POS_W-1:0] virial_xz;
    logic signed [POS_W-1:0] virial_yy;
    logic signed [POS_W-1:0] virial_yz;
    logic signed [POS_W-1:0] virial_zz;
    logic [CIRC_W-1:0]       circumference;
  } metf_out_t;

  typedef struct packed {
    logic              start;
    logic [CNT_W-1:0]  count;
    logic [ROOT_W-1:0] rem_init;
    logic [NUM_W-1:0]  num;
    logic [ROOT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [NUM_W-1:0]  quo;
    logic [ROOT_W-1:0] rem;
  } div_rsp_t;

  // position axis and force axis of each virial term, xx xy xz yy yz zz
  localparam logic [1:0] VIR_P_IDX [6] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};
  localparam logic [1:0] VIR_F_IDX [6] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};

endpackage
`default_nettype wire

@@ design/metf_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module metf_div
  import metf_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ROOT_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0]  num_q, num_d;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [ROOT_W-1:0] dvs_q, dvs_d;
  logic [ROOT_W:0]   trial;
  logic              ge;

  always_comb begin
    trial  = {rem_q, num_q[NUM_W-1]};
    ge     = trial >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.count;
      rem_d  = req_i.rem_init;
      num_d  = req_i.num;
      quo_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? ROOT_W'(trial - {1'b0, dvs_q}) : trial[ROOT_W-1:0];
      num_d = {num_q[NUM_W-2:0], 1'b0};
      quo_d = {quo_q[NUM_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule
`default_nettype wire

@@ design/metf_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
module metf_sqrt
  import metf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [PROD_W-1:0] rad_i,
  output logic                   done_o,
  output logic [ROOT_W-1:0]      root_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [PROD_W-1:0] rad_q, rad_d;
  logic [ROOT_W+1:0] rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [ROOT_W+3:0] part;
  logic [ROOT_W+1:0] trial;
  logic              ge;

  always_comb begin
    part   = {rem_q, rad_q[PROD_W-1 -: 2]};
    trial  = {root_q, 2'b01};
    ge     = part >= {2'b00, trial};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(ROOT_W);
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? (ROOT_W+2)'(part - {2'b00, trial}) : part[ROOT_W+1:0];
      root_d = {root_q[ROOT_W-2:0], ge};
      rad_d  = {rad_q[PROD_W-3:0], 2'b00};
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

@@ design/mesh_edge_tension_force.sv @@
// Boundary line-tension force on mesh bonds.
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one bond word: both end
// positions, a boundary flag and a first-bond flag. A first-bond word clears the
// running circumference. A bond off the boundary gives no output word and the
// block is ready again on the next cycle.
// A boundary bond gives two output words on out_valid_o/out_ready_i: end a, then
// end b (end_select set). Work runs on one shared restoring divider, one bit-pair
// square root and one 33x33 multiplier under a sequencer; in_ready_o is high only
// while the sequencer is idle.
// Per boundary bond the sequencer wraps each axis with a nonzero box through the
// divider, sums the squares, takes the root, forms end energy and circumference,
// then each force component, by a divide unless it saturates or the root is zero,
// then per end the virial terms (when on) and the emit, then returns to idle.
// The divider takes one bit each cycle, the root one root bit each cycle.
// The output register holds a word until taken; a stalled receiver holds the
// sequencer in its emit step, and end b is computed while end a waits.
// Reset (rst_ni low, asynchronous) restores sigma to 1.0, box lengths to zero,
// the virial off, clears the circumference and drops any word in flight.
// Configuration is to be written through cfg_we_i/cfg_idx_i/cfg_data_i while
// idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module mesh_edge_tension_force
  import metf_pkg::*;
#(
  parameter int FracBits = FRAC_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire metf_in_t         in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output metf_out_t             out_data_o,
  input  wire logic             cfg_we_i,
  input  wire logic [2:0]       cfg_idx_i,
  input  wire logic [LEN_W-1:0] cfg_data_i
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_WRAP      = 4'd1;
  localparam logic [3:0] S_WRAP_WAIT = 4'd2;
  localparam logic [3:0] S_SQ_MUL    = 4'd3;
  localparam logic [3:0] S_SQ_ACC    = 4'd4;
  localparam logic [3:0] S_SQRT      = 4'd5;
  localparam logic [3:0] S_SQRT_WAIT = 4'd6;
  localparam logic [3:0] S_EN_MUL    = 4'd7;
  localparam logic [3:0] S_EN_ACC    = 4'd8;
  localparam logic [3:0] S_F_MUL     = 4'd9;
  localparam logic [3:0] S_F_CHK     = 4'd10;
  localparam logic [3:0] S_F_WAIT    = 4'd11;
  localparam logic [3:0] S_V_MUL     = 4'd12;
  localparam logic [3:0] S_V_ACC     = 4'd13;
  localparam logic [3:0] S_EMIT      = 4'd14;

  logic [3:0] state_q, state_d;

  logic [LEN_W-1:0] sigma_q, box_x_q, box_y_q, box_z_q;
  logic             ven_q;

  logic signed [POS_W-1:0]  pa_q [3];
  logic signed [POS_W-1:0]  pb_q [3];
  logic signed [DIFF_W-1:0] d_q  [3];
  logic signed [DIFF_W-1:0] d_d;
  logic [1:0]               idx_q, idx_d;
  logic [2:0]               vidx_q, vidx_d;
  logic                     end_q, end_d;
  logic [PROD_W-1:0]        acc_q, acc_d;
  logic [PROD_W-1:0]        prod_q;
  logic [ROOT_W-1:0]        root_q, root_d;
  logic [LEN_W-1:0]         energy_q, energy_d;
  logic [CIRC_W-1:0]        circ_q, circ_d;
  logic [LEN_W-1:0]         fmag_q [3];
  logic [LEN_W-1:0]         fmag_d;
  logic                     fneg_q [3];
  logic signed [POS_W-1:0]  vir_q  [6];
  logic signed [POS_W-1:0]  vir_d;
  logic                     vir_we, vir_clr, fmag_we, d_we;

  metf_out_t out_q, out_d;
  logic      out_valid_q, out_valid_d;

  logic [ROOT_W-1:0] mul_a, mul_b;
  logic [LEN_W-1:0]  box_cur;
  logic [NUM_W-1:0]  d_mag;
  logic              in_acc;

  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     sq_start, sq_done;
  logic [ROOT_W-1:0] sq_root;

  // wrap and virial helpers
  logic [LEN_W-1:0]  r0, radj;
  logic              wneg, qodd, radj_sel;
  logic [LEN_W:0]    twor, lext;
  logic signed [POS_W-1:0] p_cur;
  logic [NUM_W-1:0]  p_mag;
  logic [LEN_W-1:0]  f_cur;
  logic              f_sign, v_neg;
  logic [PROD_W-1:0] v_shift, e_shift;
  logic [CIRC_W:0]   circ_sum;
  logic signed [POS_W-1:0] fa [3];
  logic signed [POS_W-1:0] fo [3];

  metf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  metf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (acc_q),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    unique case (idx_q)
      2'd0:    box_cur = box_x_q;
      2'd1:    box_cur = box_y_q;
      default: box_cur = box_z_q;
    endcase
  end

  assign d_mag = d_q[idx_q][DIFF_W-1] ? NUM_W'(-d_q[idx_q]) : NUM_W'(d_q[idx_q]);

  // minimum image from floor quotient parity and remainder
  always_comb begin
    wneg     = d_q[idx_q][DIFF_W-1];
    r0       = div_rsp.rem[LEN_W-1:0];
    radj_sel = wneg && (r0 != '0);
    radj     = radj_sel ? LEN_W'(box_cur - r0) : r0;
    qodd     = radj_sel ? ~div_rsp.quo[0] : div_rsp.quo[0];
    twor     = {radj, 1'b0};
    lext     = {1'b0, box_cur};
    if (twor > lext || (twor == lext && qodd)) begin
      d_d = $signed({2'b00, radj}) - $signed({2'b00, box_cur});
    end else begin
      d_d = $signed({2'b00, radj});
    end
  end

  always_comb begin
    p_cur  = end_q ? pb_q[VIR_P_IDX[vidx_q]] : pa_q[VIR_P_IDX[vidx_q]];
    p_mag  = p_cur[POS_W-1] ? NUM_W'(-p_cur) : NUM_W'(p_cur);
    f_cur  = fmag_q[VIR_F_IDX[vidx_q]];
    f_sign = (fneg_q[VIR_F_IDX[vidx_q]] ^ end_q) && (f_cur != '0);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_SQ_MUL: begin
        mul_a = ROOT_W'(d_mag);
        mul_b = ROOT_W'(d_mag);
      end
      S_EN_MUL: begin
        mul_a = ROOT_W'(sigma_q);
        mul_b = root_q;
      end
      S_F_MUL: begin
        mul_a = ROOT_W'(sigma_q);
        mul_b = ROOT_W'(d_mag);
      end
      S_V_MUL: begin
        mul_a = ROOT_W'(p_mag);
        mul_b = ROOT_W'(f_cur);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  assign v_shift  = prod_q >> (FracBits + 1);
  assign e_shift  = prod_q >> (FracBits + 1);
  assign v_neg    = p_cur[POS_W-1] ^ f_sign;
  assign circ_sum = {1'b0, circ_q} + (CIRC_W+1)'(root_q);

  always_comb begin
    if (v_neg) begin
      vir_d = (v_shift >= PROD_W'(64'h8000_0000)) ? $signed(32'h8000_0000)
                                                 : $signed(POS_W'(-v_shift));
    end else begin
      vir_d = (v_shift > PROD_W'(64'h7FFF_FFFF)) ? $signed(32'h7FFF_FFFF)
                                                : $signed(POS_W'(v_shift));
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fa[i] = fneg_q[i] ? $signed(-{1'b0, fmag_q[i]}) : $signed({1'b0, fmag_q[i]});
      fo[i] = end_q ? -fa[i] : fa[i];
    end
  end

  always_comb begin
    out_d.end_select    = end_q;
    out_d.force_x       = fo[0];
    out_d.force_y       = fo[1];
    out_d.force_z       = fo[2];
    out_d.end_energy    = energy_q;
    out_d.virial_xx     = vir_q[0];
    out_d.virial_xy     = vir_q[1];
    out_d.virial_xz     = vir_q[2];
    out_d.virial_yy     = vir_q[3];
    out_d.virial_yz     = vir_q[4];
    out_d.virial_zz     = vir_q[5];
    out_d.circumference = circ_q;
  end

  // sequencer
  always_comb begin
    state_d          = state_q;
    idx_d            = idx_q;
    vidx_d           = vidx_q;
    end_d            = end_q;
    acc_d            = acc_q;
    root_d           = root_q;
    energy_d         = energy_q;
    circ_d           = circ_q;
    fmag_d           = '0;
    fmag_we          = 1'b0;
    d_we             = 1'b0;
    vir_we           = 1'b0;
    vir_clr          = 1'b0;
    sq_start         = 1'b0;
    out_valid_d      = out_valid_q && !out_ready_i;
    div_req.start    = 1'b0;
    div_req.count    = CNT_W'(NUM_W);
    div_req.rem_init = '0;
    div_req.num      = d_mag;
    div_req.divisor  = ROOT_W'(box_cur);
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data_i.first_bond) circ_d = '0;
          idx_d = 2'd0;
          acc_d = '0;
          end_d = 1'b0;
          if (in_data_i.is_boundary) state_d = S_WRAP;
        end
      end
      S_WRAP: begin
        if (box_cur == '0) begin
          idx_d   = (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
          state_d = (idx_q == 2'd2) ? S_SQ_MUL : S_WRAP;
        end else begin
          div_req.start = 1'b1;
          state_d       = S_WRAP_WAIT;
        end
      end
      S_WRAP_WAIT: begin
        if (div_rsp.done) begin
          d_we    = 1'b1;
          idx_d   = (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
          state_d = (idx_q == 2'd2) ? S_SQ_MUL : S_WRAP;
        end
      end
      S_SQ_MUL: state_d = S_SQ_ACC;
      S_SQ_ACC: begin
        acc_d   = acc_q + prod_q;
        idx_d   = (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
        state_d = (idx_q == 2'd2) ? S_SQRT : S_SQ_MUL;
      end
      S_SQRT: begin
        sq_start = 1'b1;
        state_d  = S_SQRT_WAIT;
      end
      S_SQRT_WAIT: begin
        if (sq_done) begin
          root_d  = sq_root;
          state_d = S_EN_MUL;
        end
      end
      S_EN_MUL: state_d = S_EN_ACC;
      S_EN_ACC: begin
        energy_d = (e_shift[PROD_W-1:LEN_W] != '0) ? '1 : e_shift[LEN_W-1:0];
        circ_d   = circ_sum[CIRC_W] ? '1 : circ_sum[CIRC_W-1:0];
        idx_d    = 2'd0;
        state_d  = S_F_MUL;
      end
      S_F_MUL: state_d = S_F_CHK;
      S_F_CHK: begin
        if (root_q == '0 || prod_q[PROD_W-1:LEN_W] >= PROD_W'(root_q) >> 0) begin
          fmag_we = 1'b1;
          fmag_d  = (root_q == '0) ? '0 : '1;
        end else begin
          div_req.start    = 1'b1;
          div_req.count    = CNT_W'(LEN_W);
          div_req.rem_init = prod_q[LEN_W +: ROOT_W];
          div_req.num      = {prod_q[LEN_W-1:0], 1'b0};
          div_req.divisor  = root_q;
        end
        if (root_q == '0 || prod_q[PROD_W-1:LEN_W] >= PROD_W'(root_q) >> 0) begin
          idx_d = (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
          if (idx_q == 2'd2) begin
            vidx_d  = 3'd0;
            vir_clr = !ven_q;
            state_d = ven_q ? S_V_MUL : S_EMIT;
          end else begin
            state_d = S_F_MUL;
          end
        end else begin
          state_d = S_F_WAIT;
        end
      end
      S_F_WAIT: begin
        if (div_rsp.done) begin
          fmag_we = 1'b1;
          fmag_d  = div_rsp.quo[LEN_W-1:0];
          idx_d   = (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
          if (idx_q == 2'd2) begin
            vidx_d  = 3'd0;
            vir_clr = !ven_q;
            state_d = ven_q ? S_V_MUL : S_EMIT;
          end else begin
            state_d = S_F_MUL;
          end
        end
      end
      S_V_MUL: state_d = S_V_ACC;
      S_V_ACC: begin
        vir_we  = 1'b1;
        vidx_d  = (vidx_q == 3'd5) ? 3'd0 : vidx_q + 3'd1;
        state_d = (vidx_q == 3'd5) ? S_EMIT : S_V_MUL;
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (!end_q) begin
            end_d   = 1'b1;
            vidx_d  = 3'd0;
            state_d = ven_q ? S_V_MUL : S_EMIT;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      circ_q      <= '0;
      sigma_q     <= LEN_W'(1) << FracBits;
      box_x_q     <= '0;
      box_y_q     <= '0;
      box_z_q     <= '0;
      ven_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      circ_q      <= circ_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SIGMA:  sigma_q <= cfg_data_i;
          CFG_BOX_X:  box_x_q <= cfg_data_i;
          CFG_BOX_Y:  box_y_q <= cfg_data_i;
          CFG_BOX_Z:  box_z_q <= cfg_data_i;
          CFG_VIR_EN: ven_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    vidx_q   <= vidx_d;
    end_q    <= end_d;
    acc_q    <= acc_d;
    root_q   <= root_d;
    energy_q <= energy_d;
    if (in_acc) begin
      pa_q[0] <= in_data_i.pos_a_x;
      pa_q[1] <= in_data_i.pos_a_y;
      pa_q[2] <= in_data_i.pos_a_z;
      pb_q[0] <= in_data_i.pos_b_x;
      pb_q[1] <= in_data_i.pos_b_y;
      pb_q[2] <= in_data_i.pos_b_z;
      d_q[0]  <= DIFF_W'(in_data_i.pos_b_x) - DIFF_W'(in_data_i.pos_a_x);
      d_q[1]  <= DIFF_W'(in_data_i.pos_b_y) - DIFF_W'(in_data_i.pos_a_y);
      d_q[2]  <= DIFF_W'(in_data_i.pos_b_z) - DIFF_W'(in_data_i.pos_a_z);
    end else if (d_we) begin
      d_q[idx_q] <= d_d;
    end
    if (fmag_we) begin
      fmag_q[idx_q] <= fmag_d;
      fneg_q[idx_q] <= d_q[idx_q][DIFF_W-1];
    end
    if (vir_clr) begin
      for (int i = 0; i < 6; i++) vir_q[i] <= '0;
    end else if (vir_we) begin
      vir_q[vidx_q] <= vir_d;
    end
    if (out_valid_d && !(out_valid_q && !out_ready_i)) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_skip_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !in_data_i.is_boundary |=> in_ready_o)
    else $error("non-boundary bond left the sequencer busy");

  a_end_b_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.end_select |-> state_q != S_IDLE)
    else $error("end a word shown with no end b word pending");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> (state_q == S_WRAP_WAIT || state_q == S_F_WAIT))
    else $error("divider busy outside a divide wait");

endmodule
`default_nettype wire
